// ===== src/mfi_pkg.sv =====
`default_nettype none
package mfi_pkg;

   localparam int WINDOW_DEFAULT = 14;

   localparam int PRICE_W     = 24;
   localparam int VOL_W       = 32;
   localparam int TYP_W       = 26;
   localparam int MAG_W       = 58;
   localparam int DPROD_W     = 56;
   localparam int WEIGHT_W    = 17;
   localparam int CSR_INDEX_W = 2;
   localparam int MFI_W       = 23;
   localparam int FR_W        = 64;
   localparam int FR_Q_W      = 63;
   localparam int VR_W        = 20;
   localparam int SFI_W       = 21;
   localparam int NORM_W      = 17;
   localparam int REQ_DATA_W  = 128;
   localparam int RSP_DATA_W  = 200;

   // Reciprocal of 100 scaled by 2^32, rounded up; exact for 23-bit dividends.
   localparam int          RECIP_W    = 26;
   localparam int          NORM_SHIFT = 32;
   localparam logic [RECIP_W-1:0] RECIP_100 = 26'd42949673;

   localparam logic [WEIGHT_W-1:0] WEIGHT_MFI_RESET    = 17'd32768;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ENERGY_RESET = 17'd19661;
   localparam logic [WEIGHT_W-1:0] WEIGHT_VR_RESET     = 17'd13107;

   localparam logic [VR_W-1:0]  VR_MAX  = 20'hFFFFF;
   localparam logic [SFI_W-1:0] SFI_MAX = 21'h1FFFFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WEIGHT_MFI          = 2'd0,
      CSR_WEIGHT_ENERGY       = 2'd1,
      CSR_WEIGHT_VOLUME_RATIO = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_UPD,
      ST_PREP,
      ST_START,
      ST_DIV,
      ST_NORM,
      ST_WGT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic mul;
      logic upd;
      logic prep;
      logic start;
      logic norm;
      logic wgt;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic div_busy;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== src/money_flow_indicator_top.sv =====
`default_nettype none
// Money flow indicator: one price bar per item (open, high, low, close, volume) in,
// one result per bar out with a windowed money flow index, flow ratio, cumulative
// flow, volume ratio and a weighted smart flow index. The 63-step flow ratio
// division in the serial dividers is the longest step of a bar, with the money flow
// and volume divisions running beside it. A new bar is taken as soon as the
// previous one has reached the output register, even while that result still
// waits. Weights are written through the csr port; the user must write them only
// while no bar is in work, as the block itself does not enforce it.
module money_flow_indicator_top #(
   parameter int WINDOW = mfi_pkg::WINDOW_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // open_price, high_price, low_price, close_price, bar_volume
   input  wire logic [mfi_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // mfi_value, mfi_valid, ratio value, ratio valid flag, cumulative_flow,
   // volume_ratio, smart_flow_index, zero fill
   output logic [mfi_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                             csr_we,
   input  wire logic [mfi_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [mfi_pkg::WEIGHT_W-1:0]     csr_wdata
);
   mfi_pkg::dp_cmd_type    cmd;
   mfi_pkg::dp_status_type status;

   mfi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mfi_dp #(.WINDOW(WINDOW)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule
`default_nettype wire

// ===== src/mfi_div.sv =====
`default_nettype none
module mfi_div #(
   parameter int D_W = 32,
   parameter int Q_W = 32
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [D_W-1:0] rem_init,
   input  wire logic [Q_W-1:0] num_low,
   input  wire logic [D_W-1:0] divisor,
   output logic                busy,
   output logic [Q_W-1:0]      quotient
);
   localparam int CNT_W = $clog2(Q_W + 1);

   logic [D_W-1:0]   rem_ff, rem_in;
   logic [Q_W-1:0]   quo_ff, quo_in;
   logic [D_W-1:0]   den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [D_W:0]     trial;
   logic [D_W:0]     trial_sub;
   logic             ge;

   // The quotient shifts in at the bottom as the dividend bits leave the top.
   always_comb begin
      trial     = {rem_ff, quo_ff[Q_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      ge        = trial >= {1'b0, den_ff};
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      den_in    = den_ff;
      cnt_in    = cnt_ff;
      if (start) begin
         rem_in = rem_init;
         quo_in = num_low;
         den_in = divisor;
         cnt_in = CNT_W'(Q_W);
      end else if (cnt_ff != '0) begin
         rem_in = ge ? trial_sub[D_W-1:0] : trial[D_W-1:0];
         quo_in = {quo_ff[Q_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign busy     = cnt_ff != '0;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== src/mfi_dp.sv =====
`default_nettype none
module mfi_dp #(
   parameter int WINDOW = mfi_pkg::WINDOW_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire mfi_pkg::dp_cmd_type                 cmd,
   output mfi_pkg::dp_status_type                   status,
   input  wire logic [mfi_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic [mfi_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [mfi_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [mfi_pkg::WEIGHT_W-1:0]        csr_wdata
);
   localparam int PW      = mfi_pkg::PRICE_W;
   localparam int VW      = mfi_pkg::VOL_W;
   localparam int TW      = mfi_pkg::TYP_W;
   localparam int MW      = mfi_pkg::MAG_W;
   localparam int DPW     = mfi_pkg::DPROD_W;
   localparam int WW      = mfi_pkg::WEIGHT_W;
   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int POS_W   = $clog2(WINDOW);
   localparam int VSUM_W  = VW + CNT_W;
   localparam int FSUM_W  = MW + CNT_W;
   localparam int MSUM_W  = FSUM_W + 1;
   localparam int P100_W  = FSUM_W + 7;
   localparam int VQ_W    = 16 + CNT_W;
   localparam int ENTRY_W = 1 + MW + VW;
   localparam int NPROD_W = mfi_pkg::MFI_W + mfi_pkg::RECIP_W;
   localparam int WM_W    = 2 * WW;
   localparam int WV_W    = WW + 1 + mfi_pkg::VR_W;
   localparam int SUM_W   = WV_W + 1;
   localparam int VRC_W   = VQ_W + mfi_pkg::VR_W;

   // configuration
   logic [WW-1:0] w_mfi_ff, w_energy_ff, w_vr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_mfi_ff    <= mfi_pkg::WEIGHT_MFI_RESET;
         w_energy_ff <= mfi_pkg::WEIGHT_ENERGY_RESET;
         w_vr_ff     <= mfi_pkg::WEIGHT_VR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            mfi_pkg::CSR_WEIGHT_MFI:          w_mfi_ff    <= csr_wdata;
            mfi_pkg::CSR_WEIGHT_ENERGY:       w_energy_ff <= csr_wdata;
            mfi_pkg::CSR_WEIGHT_VOLUME_RATIO: w_vr_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // captured item
   logic [PW-1:0] open_ff, close_ff;
   logic [VW-1:0] vol_ff;
   logic [TW-1:0] typ_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         open_ff  <= req_tdata[PW-1:0];
         close_ff <= req_tdata[4*PW-1:3*PW];
         vol_ff   <= req_tdata[4*PW+VW-1:4*PW];
         typ_ff   <= TW'(req_tdata[2*PW-1:PW]) + TW'(req_tdata[3*PW-1:2*PW])
                     + TW'(req_tdata[4*PW-1:3*PW]);
      end
   end

   // history memory: flow sign, flow magnitude, volume
   logic [ENTRY_W-1:0] hist_mem [WINDOW];
   logic [ENTRY_W-1:0] rd_ff;
   logic [POS_W-1:0]   pos_ff;

   // products
   logic [MW-1:0]     mag_ff;
   logic [DPW-1:0]    dprod_ff;
   logic [VSUM_W-1:0] vw_ff;
   logic              neg_ff;
   logic [PW-1:0]     diff;

   assign diff = (close_ff < open_ff) ? open_ff - close_ff : close_ff - open_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         mag_ff   <= MW'(typ_ff) * MW'(vol_ff);
         dprod_ff <= DPW'(diff) * DPW'(vol_ff);
         vw_ff    <= VSUM_W'(vol_ff) * VSUM_W'(WINDOW);
         neg_ff   <= close_ff < open_ff;
      end
   end

   // window state
   logic [CNT_W-1:0]  seen_ff;
   logic [TW-1:0]     ptyp_ff;
   logic [VW-1:0]     pvol_ff;
   logic [FSUM_W-1:0] psum_ff, nsum_ff;
   logic [VSUM_W-1:0] vsum_ff;
   logic [VW-1:0]     fr_den_ff;
   logic              fr_ok_ff, mfi_en_ff, vr_en_ff;

   logic              full;
   logic              has_prev;
   logic [ENTRY_W-1:0] old_entry;
   logic              old_neg, new_neg;
   logic [MW-1:0]     old_mag, new_mag;
   logic [VW-1:0]     old_vol;
   logic [FSUM_W-1:0] psum_in, nsum_in;

   // Entries not yet written read as zero: the ring fills in order.
   always_comb begin
      full      = seen_ff == CNT_W'(WINDOW);
      has_prev  = seen_ff != '0;
      old_entry = full ? rd_ff : '0;
      old_neg   = old_entry[ENTRY_W-1];
      old_mag   = old_entry[ENTRY_W-2:VW];
      old_vol   = old_entry[VW-1:0];
      new_neg   = has_prev && (typ_ff < ptyp_ff);
      new_mag   = (has_prev && (typ_ff != ptyp_ff)) ? mag_ff : '0;
      psum_in   = psum_ff - (old_neg ? '0 : FSUM_W'(old_mag))
                  + (new_neg ? '0 : FSUM_W'(new_mag));
      nsum_in   = nsum_ff - (old_neg ? FSUM_W'(old_mag) : '0)
                  + (new_neg ? FSUM_W'(new_mag) : '0);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_ff <= hist_mem[pos_ff];
      end
      if (cmd.upd) begin
         hist_mem[pos_ff] <= {new_neg, new_mag, vol_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         pos_ff  <= '0;
         ptyp_ff <= '0;
         pvol_ff <= '0;
         psum_ff <= '0;
         nsum_ff <= '0;
         vsum_ff <= '0;
      end else if (cmd.upd) begin
         seen_ff <= full ? seen_ff : seen_ff + 1'b1;
         pos_ff  <= (pos_ff == POS_W'(WINDOW - 1)) ? '0 : pos_ff + 1'b1;
         ptyp_ff <= typ_ff;
         pvol_ff <= vol_ff;
         psum_ff <= psum_in;
         nsum_ff <= nsum_in;
         vsum_ff <= vsum_ff - VSUM_W'(old_vol) + VSUM_W'(vol_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         fr_den_ff <= pvol_ff;
         fr_ok_ff  <= has_prev && (pvol_ff != '0);
         mfi_en_ff <= full;
         vr_en_ff  <= (CNT_W+1)'(seen_ff) + 1'b1 >= (CNT_W+1)'(WINDOW);
      end
   end

   // divider operands
   logic [P100_W-1:0] p100_ff;
   logic [MSUM_W-1:0] spn_ff;
   logic              mfi_ok_ff, vr_ok_ff, fr_sat_ff;

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         p100_ff   <= (P100_W'(psum_ff) << 6) + (P100_W'(psum_ff) << 5)
                      + (P100_W'(psum_ff) << 2);
         spn_ff    <= MSUM_W'(psum_ff) + MSUM_W'(nsum_ff);
         mfi_ok_ff <= mfi_en_ff && (nsum_ff != '0);
         vr_ok_ff  <= vr_en_ff && (vsum_ff != '0);
         fr_sat_ff <= VW'(dprod_ff[DPW-1:mfi_pkg::FR_Q_W-16]) >= fr_den_ff;
      end
   end

   logic [mfi_pkg::MFI_W-1:0]  mfi_q;
   logic [mfi_pkg::FR_Q_W-1:0] fr_q;
   logic [VQ_W-1:0]            vr_q;
   logic                       busy_mfi, busy_fr, busy_vr;

   mfi_div #(.D_W(MSUM_W), .Q_W(mfi_pkg::MFI_W)) u_div_mfi (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start),
      .rem_init (MSUM_W'(p100_ff[P100_W-1:7])),
      .num_low  ({p100_ff[6:0], 16'b0}),
      .divisor  (spn_ff),
      .busy     (busy_mfi),
      .quotient (mfi_q)
   );

   mfi_div #(.D_W(VW), .Q_W(mfi_pkg::FR_Q_W)) u_div_fr (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start),
      .rem_init (VW'(dprod_ff[DPW-1:mfi_pkg::FR_Q_W-16])),
      .num_low  ({dprod_ff[mfi_pkg::FR_Q_W-17:0], 16'b0}),
      .divisor  (fr_den_ff),
      .busy     (busy_fr),
      .quotient (fr_q)
   );

   mfi_div #(.D_W(VSUM_W), .Q_W(VQ_W)) u_div_vr (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start),
      .rem_init (VSUM_W'(vw_ff[VSUM_W-1:CNT_W])),
      .num_low  ({vw_ff[CNT_W-1:0], 16'b0}),
      .divisor  (vsum_ff),
      .busy     (busy_vr),
      .quotient (vr_q)
   );

   assign status.div_busy = busy_mfi || busy_fr || busy_vr;

   // results
   logic [mfi_pkg::MFI_W-1:0] mfi_val;
   logic [mfi_pkg::FR_W-1:0]  fr_val;
   logic [mfi_pkg::FR_W-1:0]  run_ff, run_sum, run_in;
   logic [mfi_pkg::VR_W-1:0]  vr_val;
   logic [VRC_W-1:0]          vr_wide;
   logic [NPROD_W-1:0]        nprod_ff;
   logic [mfi_pkg::MFI_W-1:0] mfi_val_ff;
   logic [mfi_pkg::FR_W-1:0]  fr_val_ff;
   logic [mfi_pkg::VR_W-1:0]  vr_val_ff;

   always_comb begin
      mfi_val = mfi_ok_ff ? mfi_q : '0;
      fr_val  = '0;
      if (fr_ok_ff) begin
         if (neg_ff) begin
            fr_val = fr_sat_ff ? {1'b1, 63'b0} : -{1'b0, fr_q};
         end else begin
            fr_val = fr_sat_ff ? {1'b0, {63{1'b1}}} : {1'b0, fr_q};
         end
      end
      run_sum = run_ff + fr_val;
      run_in  = run_sum;
      // Signed saturation: operands agree in sign but the sum does not.
      if (run_ff[63] == fr_val[63] && run_sum[63] != run_ff[63]) begin
         run_in = run_ff[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      end
      vr_wide = VRC_W'(vr_q);
      if (!vr_ok_ff) begin
         vr_val = '0;
      end else if (vr_wide > VRC_W'(mfi_pkg::VR_MAX)) begin
         vr_val = mfi_pkg::VR_MAX;
      end else begin
         vr_val = vr_wide[mfi_pkg::VR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else if (cmd.norm && fr_ok_ff) begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.norm) begin
         mfi_val_ff <= mfi_val;
         fr_val_ff  <= fr_val;
         vr_val_ff  <= vr_val;
         nprod_ff   <= NPROD_W'(mfi_val) * NPROD_W'(mfi_pkg::RECIP_100);
      end
   end

   logic [WM_W-1:0] wm_ff;
   logic [WV_W-1:0] wv_ff;

   always_ff @(posedge clock) begin
      if (cmd.wgt) begin
         wm_ff <= WM_W'(w_mfi_ff)
                  * WM_W'(nprod_ff[mfi_pkg::NORM_SHIFT+mfi_pkg::NORM_W-1:mfi_pkg::NORM_SHIFT]);
         wv_ff <= WV_W'(WV_W'(w_energy_ff) + WV_W'(w_vr_ff)) * WV_W'(vr_val_ff);
      end
   end

   logic [SUM_W-1:0]          sfi_sum;
   logic [SUM_W-17:0]         sfi_shr;
   logic [mfi_pkg::SFI_W-1:0] sfi_val;

   always_comb begin
      sfi_sum = SUM_W'(wm_ff) + SUM_W'(wv_ff);
      sfi_shr = sfi_sum[SUM_W-1:16];
      sfi_val = (sfi_shr > (SUM_W-16)'(mfi_pkg::SFI_MAX)) ? mfi_pkg::SFI_MAX
                : sfi_shr[mfi_pkg::SFI_W-1:0];
   end

   // output register
   logic [mfi_pkg::MFI_W-1:0] o_mfi_ff;
   logic                      o_mfi_ok_ff, o_fr_ok_ff;
   logic [mfi_pkg::FR_W-1:0]  o_fr_ff, o_cum_ff;
   logic [mfi_pkg::VR_W-1:0]  o_vr_ff;
   logic [mfi_pkg::SFI_W-1:0] o_sfi_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         o_mfi_ff    <= mfi_val_ff;
         o_mfi_ok_ff <= mfi_ok_ff;
         o_fr_ff     <= fr_val_ff;
         o_fr_ok_ff  <= fr_ok_ff;
         o_cum_ff    <= run_ff;
         o_vr_ff     <= vr_val_ff;
         o_sfi_ff    <= sfi_val;
      end
   end

   assign rsp_tdata = {6'b0, o_sfi_ff, o_vr_ff, o_cum_ff,
                       o_fr_ok_ff, o_fr_ff, o_mfi_ok_ff, o_mfi_ff};

endmodule
`default_nettype wire

// ===== src/mfi_ctrl.sv =====
`default_nettype none
module mfi_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire mfi_pkg::dp_status_type status,
   output mfi_pkg::dp_cmd_type         cmd
);
   mfi_pkg::state_type state_ff, state_in;
   logic               out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfi_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         mfi_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = mfi_pkg::ST_MUL;
            end
         end
         mfi_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = mfi_pkg::ST_UPD;
         end
         mfi_pkg::ST_UPD: begin
            cmd.upd  = 1'b1;
            state_in = mfi_pkg::ST_PREP;
         end
         mfi_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = mfi_pkg::ST_START;
         end
         mfi_pkg::ST_START: begin
            cmd.start = 1'b1;
            state_in  = mfi_pkg::ST_DIV;
         end
         mfi_pkg::ST_DIV: begin
            if (!status.div_busy) begin
               state_in = mfi_pkg::ST_NORM;
            end
         end
         mfi_pkg::ST_NORM: begin
            cmd.norm = 1'b1;
            state_in = mfi_pkg::ST_WGT;
         end
         mfi_pkg::ST_WGT: begin
            cmd.wgt  = 1'b1;
            state_in = mfi_pkg::ST_OUT;
         end
         mfi_pkg::ST_OUT: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = mfi_pkg::ST_IDLE;
            end
         end
         default: state_in = mfi_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign req_tready = state_ff == mfi_pkg::ST_IDLE;
   assign rsp_tvalid = out_valid_ff;

`ifndef NO_ASSERTIONS
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_tvalid)
      else $error("loaded result not presented");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!out_valid_ff || rsp_tready))
      else $error("result overwritten before taken");
   a_start_idle_div: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !status.div_busy)
      else $error("divider started while busy");
   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> status.div_busy)
      else $error("divider did not start");
`endif

endmodule
`default_nettype wire

// ===== dv/money_flow_indicator_top_test.sv =====
`default_nettype none
module money_flow_indicator_top_test;

   localparam int BARS = 14;
   localparam int IDLE_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 120;
   localparam int HOLD_CYCLES = 400;
   localparam logic [63:0] FLOW_MASK = (64'd1 << 59) - 64'd1;
   localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam mfi_pkg::csr_index_type CSR_UNMAPPED = mfi_pkg::csr_index_type'(2'd3);

   typedef struct packed {
      logic [23:0] open_px;
      logic [23:0] high_px;
      logic [23:0] low_px;
      logic [23:0] close_px;
      logic [31:0] volume;
   } bar_type;

   typedef struct packed {
      logic [22:0] mfi;
      logic        mfi_ok;
      logic [63:0] ratio;
      logic        ratio_ok;
      logic [63:0] total_flow;
      logic [19:0] vr_rel;
      logic [20:0] smart;
   } flow_result_type;

   typedef struct packed {
      bar_type         bar;
      logic            typed;
      flow_result_type want;
   } bar_row_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [mfi_pkg::REQ_DATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [mfi_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we;
   mfi_pkg::csr_index_type csr_index;
   logic [mfi_pkg::WEIGHT_W-1:0] csr_wdata;

   money_flow_indicator_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Predictor state.
   logic [16:0] w_mfi, w_energy, w_vr;
   logic [63:0] prev_typ, prev_vol, vol_sum, pos_sum, neg_sum, running_flow;
   logic [63:0] vol_hist [BARS];
   logic [63:0] flow_hist [BARS];
   int bars_before, slot;

   flow_result_type results_due[$];
   int errors = 0;
   int bars_sent = 0;
   int results_seen = 0;
   int idle_cycles = 0;
   bit hold_request = 0;
   bar_type last_bar;
   logic [23:0] walk_px;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic flow_result_type predict_bar(bar_type b);
      logic [63:0] typ, flow, old, diff, vr, norm, sfi, sum;
      logic [127:0] num, q;
      logic neg;
      flow_result_type r;
      r = '0;
      typ = 64'(b.high_px) + 64'(b.low_px) + 64'(b.close_px);
      flow = 0;
      if (bars_before > 0) begin
         if (typ > prev_typ) flow = (typ * 64'(b.volume)) & FLOW_MASK;
         else if (typ < prev_typ) flow = (-(typ * 64'(b.volume))) & FLOW_MASK;
      end
      old = flow_hist[slot];
      if (old[58]) neg_sum = neg_sum - ((-old) & FLOW_MASK);
      else pos_sum = pos_sum - old;
      if (flow[58]) neg_sum = neg_sum + ((-flow) & FLOW_MASK);
      else pos_sum = pos_sum + flow;
      flow_hist[slot] = flow;
      vol_sum = vol_sum - vol_hist[slot] + 64'(b.volume);
      vol_hist[slot] = 64'(b.volume);
      slot = (slot + 1) % BARS;

      if (bars_before >= BARS && neg_sum != 0) begin
         num = 128'(6553600) * 128'(pos_sum);
         q = num / (128'(pos_sum) + 128'(neg_sum));
         r.mfi = q[22:0];
         r.mfi_ok = 1;
      end

      if (bars_before > 0 && prev_vol > 0) begin
         neg = b.close_px < b.open_px;
         diff = neg ? 64'(b.open_px - b.close_px) : 64'(b.close_px - b.open_px);
         num = 128'(diff * 64'(b.volume)) << 16;
         q = num / 128'(prev_vol);
         if (neg) begin
            if (q > 128'(S64_MIN)) q = 128'(S64_MIN);
            r.ratio = -q[63:0];
         end else begin
            if (q > 128'(S64_MAX)) q = 128'(S64_MAX);
            r.ratio = q[63:0];
         end
         r.ratio_ok = 1;
         sum = running_flow + r.ratio;
         if (running_flow[63] == r.ratio[63] && sum[63] != running_flow[63])
            sum = running_flow[63] ? S64_MIN : S64_MAX;
         running_flow = sum;
      end
      r.total_flow = running_flow;

      vr = 0;
      if (bars_before + 1 >= BARS && vol_sum != 0) begin
         vr = ((64'(b.volume) * BARS) << 16) / vol_sum;
         if (vr > 64'(mfi_pkg::VR_MAX)) vr = 64'(mfi_pkg::VR_MAX);
      end
      r.vr_rel = vr[19:0];
      norm = r.mfi_ok ? 64'(r.mfi) / 100 : 0;
      sfi = (64'(w_mfi) * norm + (64'(w_energy) + 64'(w_vr)) * vr) >> 16;
      if (sfi > 64'(mfi_pkg::SFI_MAX)) sfi = 64'(mfi_pkg::SFI_MAX);
      r.smart = sfi[20:0];

      prev_typ = typ;
      prev_vol = 64'(b.volume);
      if (bars_before < BARS) bars_before++;
      return r;
   endfunction

   function automatic bar_type mk_bar(logic [31:0] o, logic [31:0] h, logic [31:0] l,
                                      logic [31:0] c, logic [31:0] v);
      bar_type b;
      b.open_px = o[23:0];
      b.high_px = h[23:0];
      b.low_px = l[23:0];
      b.close_px = c[23:0];
      b.volume = v;
      return b;
   endfunction

   function automatic bar_type random_bar();
      bar_type b;
      int kind;
      int step;
      kind = $urandom_range(0, 15);
      if (kind == 0) begin
         b = mk_bar($urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (kind == 1) begin
         // Same prices again, so the typical sum does not move.
         b = last_bar;
         b.volume = $urandom_range(0, 5000);
      end else begin
         step = $urandom_range(0, 400);
         step = step - 200;
         if (walk_px < 24'd2000 || walk_px > 24'd16770000)
            walk_px = 24'($urandom_range(2000, 16770000));
         walk_px = 24'(int'(walk_px) + step);
         b.low_px = 24'(walk_px - $urandom_range(0, 300));
         b.high_px = 24'(walk_px + $urandom_range(0, 300));
         b.open_px = 24'($urandom_range(b.low_px, b.high_px));
         b.close_px = 24'($urandom_range(b.low_px, b.high_px));
         case ($urandom_range(0, 9))
            0: b.volume = 0;
            1: b.volume = $urandom;
            default: b.volume = $urandom_range(1, 100000);
         endcase
      end
      last_bar = b;
      return b;
   endfunction

   task automatic report(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch on result %0d, %s: got %h, wanted %h", results_seen, field, got,
               want);
      errors++;
   endtask

   task automatic send_bar(bar_type b, logic typed, flow_result_type want);
      flow_result_type r;
      @(negedge clock);
      req_tvalid <= 1;
      req_tdata <= {b.volume, b.close_px, b.low_px, b.high_px, b.open_px};
      do @(posedge clock); while (!req_tready);
      r = predict_bar(b);
      results_due.push_back(typed ? want : r);
      bars_sent++;
   endtask

   task automatic pause_sender(int cycles);
      @(negedge clock);
      req_tvalid <= 0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Registers are only touched once the block has drained.
   task automatic write_weight(mfi_pkg::csr_index_type idx, logic [16:0] value);
      pause_sender(1);
      wait (results_due.size() == 0);
      pause_sender(SETTLE_CYCLES);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 0;
      case (idx)
         mfi_pkg::CSR_WEIGHT_MFI: w_mfi = value;
         mfi_pkg::CSR_WEIGHT_ENERGY: w_energy = value;
         mfi_pkg::CSR_WEIGHT_VOLUME_RATIO: w_vr = value;
         default: ;
      endcase
   endtask

   task automatic random_phase(int count, bit with_hold);
      int burst;
      int left;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 30);
         if (with_hold && left < count / 2) begin
            hold_request = 1;
            with_hold = 0;
         end
         while (burst > 0 && left > 0) begin
            send_bar(random_bar(), 0, '0);
            burst--;
            left--;
         end
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 15));
      end
   endtask

   // Receiver: its own stall pattern, plus one long hold on request.
   initial begin
      int mode;
      int count;
      rsp_tready = 0;
      count = 0;
      mode = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            rsp_tready <= 0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (count == 0) begin
               mode = $urandom_range(0, 2);
               count = $urandom_range(20, 200);
            end
            count--;
            case (mode)
               0: rsp_tready <= 1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      flow_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.mfi = rsp_tdata[22:0];
         got.mfi_ok = rsp_tdata[23];
         got.ratio = rsp_tdata[87:24];
         got.ratio_ok = rsp_tdata[88];
         got.total_flow = rsp_tdata[152:89];
         got.vr_rel = rsp_tdata[172:153];
         got.smart = rsp_tdata[193:173];
         if (results_due.size() == 0) begin
            $display("result %0d arrived with no bar outstanding", results_seen);
            errors++;
         end else begin
            want = results_due.pop_front();
            if (got.mfi != want.mfi) report("mfi_value", 64'(got.mfi), 64'(want.mfi));
            if (got.mfi_ok != want.mfi_ok)
               report("mfi_valid", 64'(got.mfi_ok), 64'(want.mfi_ok));
            if (got.ratio != want.ratio) report("ratio", got.ratio, want.ratio);
            if (got.ratio_ok != want.ratio_ok)
               report("ratio_valid", 64'(got.ratio_ok), 64'(want.ratio_ok));
            if (got.total_flow != want.total_flow)
               report("cumulative_flow", got.total_flow, want.total_flow);
            if (got.vr_rel != want.vr_rel)
               report("volume_ratio", 64'(got.vr_rel), 64'(want.vr_rel));
            if (got.smart != want.smart)
               report("smart_flow_index", 64'(got.smart), 64'(want.smart));
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("no progress for %0d cycles, %0d results outstanding", IDLE_LIMIT,
                  results_due.size());
         $display("money_flow_indicator_top_test failed");
         $finish;
      end
   end

   initial begin
      bar_row_type rows [25];
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      csr_we = 0;
      csr_index = mfi_pkg::CSR_WEIGHT_MFI;
      csr_wdata = '0;
      w_mfi = mfi_pkg::WEIGHT_MFI_RESET;
      w_energy = mfi_pkg::WEIGHT_ENERGY_RESET;
      w_vr = mfi_pkg::WEIGHT_VR_RESET;
      prev_typ = 0; prev_vol = 0; vol_sum = 0; pos_sum = 0; neg_sum = 0; running_flow = 0;
      bars_before = 0;
      slot = 0;
      for (int i = 0; i < BARS; i++) begin
         vol_hist[i] = 0;
         flow_hist[i] = 0;
      end
      walk_px = 24'd5000000;
      last_bar = '0;

      // The first bar after reset gives nothing but zeros and cleared flags.
      rows[0] = '{mk_bar(0, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFFFF), 1, '0};
      rows[1] = '{mk_bar(32'hFFFFFF, 0, 0, 0, 0), 0, '0};
      // Previous volume is zero here, so no flow ratio.
      rows[2] = '{mk_bar(0, 0, 0, 0, 1), 0, '0};
      // Largest rise over a volume of one saturates upward.
      rows[3] = '{mk_bar(0, 32'hFFFFFF, 0, 32'hFFFFFF, 32'hFFFFFFFF), 0, '0};
      rows[4] = '{mk_bar(0, 0, 0, 0, 1), 0, '0};
      rows[5] = '{mk_bar(32'hFFFFFF, 32'hFFFFFF, 0, 0, 32'hFFFFFFFF), 0, '0};
      rows[6] = '{mk_bar(32'hFFFFFF, 32'hFFFFFF, 0, 0, 5), 0, '0};
      // Zero-volume climb: the window empties of flows and volume.
      for (int i = 7; i < 21; i++)
         rows[i] = '{mk_bar(1000 + i, 1100 + i * 10, 900 + i * 10, 1000 + i * 10, 0), 0, '0};
      rows[21] = '{mk_bar(2000, 2300, 1900, 2200, 100), 0, '0};
      rows[22] = '{mk_bar(2200, 2500, 2100, 2400, 300), 0, '0};
      rows[23] = '{mk_bar(2400, 2400, 1500, 1600, 200), 0, '0};
      rows[24] = '{mk_bar(1600, 1700, 1200, 1300, 32'hFFFFFFFF), 0, '0};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (rows[i]) send_bar(rows[i].bar, rows[i].typed, rows[i].want);
      pause_sender(1);
      wait (results_due.size() == 0);

      random_phase(190, 1);
      write_weight(mfi_pkg::CSR_WEIGHT_MFI, 17'd0);
      write_weight(mfi_pkg::CSR_WEIGHT_ENERGY, 17'd0);
      write_weight(mfi_pkg::CSR_WEIGHT_VOLUME_RATIO, 17'd0);
      random_phase(150, 0);
      write_weight(mfi_pkg::CSR_WEIGHT_MFI, 17'd65536);
      write_weight(mfi_pkg::CSR_WEIGHT_ENERGY, 17'd65536);
      write_weight(mfi_pkg::CSR_WEIGHT_VOLUME_RATIO, 17'd65536);
      // A write to the unused index must leave every weight alone.
      write_weight(CSR_UNMAPPED, 17'd12345);
      random_phase(200, 0);
      write_weight(mfi_pkg::CSR_WEIGHT_MFI, 17'($urandom_range(0, 65536)));
      write_weight(mfi_pkg::CSR_WEIGHT_ENERGY, 17'($urandom_range(0, 65536)));
      write_weight(mfi_pkg::CSR_WEIGHT_VOLUME_RATIO, 17'($urandom_range(0, 65536)));
      random_phase(200, 1);
      write_weight(mfi_pkg::CSR_WEIGHT_MFI, 17'd1);
      write_weight(mfi_pkg::CSR_WEIGHT_ENERGY, 17'd65536);
      write_weight(mfi_pkg::CSR_WEIGHT_VOLUME_RATIO, 17'd0);
      random_phase(190, 0);

      pause_sender(1);
      wait (results_due.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d bars sent and %0d results checked over five weight settings,", bars_sent,
               results_seen);
      $display("including saturated ratios, flat bars, empty windows and two long output stalls.");
      if (errors == 0)
         $display("money_flow_indicator_top_test passed");
      else
         $display("money_flow_indicator_top_test failed");
      $finish;
   end
endmodule
`default_nettype wire
